// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/htok_pkg.sv =====
// Types, constants and helper functions of the HTTP request tokenizer.
package htok_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PATH    = 4'd1,
        PH_QNAME   = 4'd2,
        PH_QVALUE  = 4'd3,
        PH_VERSION = 4'd4,
        PH_HNAME   = 4'd5,
        PH_HVALUE  = 4'd6,
        PH_BLANK   = 4'd7,
        PH_BODY    = 4'd8,
        PH_ERROR   = 4'd9
    } t_phase;

    // Field kinds.
    localparam logic [2:0] K_METHOD  = 3'd0;
    localparam logic [2:0] K_PATH    = 3'd1;
    localparam logic [2:0] K_QNAME   = 3'd2;
    localparam logic [2:0] K_QVALUE  = 3'd3;
    localparam logic [2:0] K_VERSION = 3'd4;
    localparam logic [2:0] K_HNAME   = 3'd5;
    localparam logic [2:0] K_HVALUE  = 3'd6;
    localparam logic [2:0] K_BODY    = 3'd7;

    // Error codes.
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_UNTERM  = 2'd1;
    localparam logic [1:0] E_NOCOLON = 2'd2;
    localparam logic [1:0] E_ESCAPE  = 2'd3;

    // Characters.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Result queue sizing.
    localparam int MAX_RES  = 3;
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;
    localparam int RQ_ROOM  = RQ_DEPTH - MAX_RES;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_kind;
        logic       field_end;
        logic       discard_field;
        logic [1:0] error_code;
        logic       last_of_run;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_res_set;

    // Results of one word and how many of them are valid.
    typedef struct packed {
        t_res_set   res;
        logic [1:0] cnt;
    } t_step_out;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] escape_step;
        logic [3:0] first_nibble;
        logic       held_cr;
        logic       line_start;
        logic       skipping_spaces;
        logic       name_open;
    } t_state;

    localparam t_state ST_RESET = '{
        phase: PH_METHOD, escape_step: 2'd0, first_nibble: 4'd0,
        held_cr: 1'b0, line_start: 1'b0, skipping_spaces: 1'b0, name_open: 1'b0
    };

    function automatic t_result mk_res(logic [7:0] b, logic [2:0] k, logic e, logic d,
                                       logic [1:0] err);
        t_result r;
        r.out_byte      = b;
        r.field_kind    = k;
        r.field_end     = e;
        r.discard_field = d;
        r.error_code    = err;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [2:0] kind_of(t_phase p);
        logic [2:0] k;
        unique case (p)
            PH_METHOD:  k = K_METHOD;
            PH_PATH:    k = K_PATH;
            PH_QNAME:   k = K_QNAME;
            PH_QVALUE:  k = K_QVALUE;
            PH_VERSION: k = K_VERSION;
            PH_HNAME:   k = K_HNAME;
            PH_HVALUE:  k = K_HVALUE;
            PH_BLANK:   k = K_BODY;
            PH_BODY:    k = K_BODY;
            default:    k = K_METHOD;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/htok_step.sv =====
// Parser state register and the per-word classification logic.
`include "assert_macros.svh"

module htok_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_eor,
    output htok_pkg::t_step_out  o_out
);

    htok_pkg::t_state r_st;
    htok_pkg::t_state n_step;
    htok_pkg::t_state n_st;

    logic [4:0] hx;
    logic       hex_ok;
    logic [3:0] nib;
    logic       u_err;
    logic       u_take;
    logic       u_space;
    logic [7:0] u_dec;
    logic [7:0] u_sep;
    logic       sep_hit;
    logic [2:0] kind;

    // Shared decode of the URI part.
    assign hx      = htok_pkg::hex_val(i_byte);
    assign hex_ok  = hx[4];
    assign nib     = hx[3:0];
    assign u_err   = (r_st.escape_step != 2'd0) && !hex_ok;
    assign u_space = (r_st.escape_step == 2'd0) && (i_byte == htok_pkg::CH_SP);
    assign u_take  = ((r_st.escape_step == 2'd2) && hex_ok)
                   || ((r_st.escape_step == 2'd0) && (i_byte != htok_pkg::CH_SP)
                       && (i_byte != htok_pkg::CH_PCT));
    assign u_dec   = (r_st.escape_step == 2'd2) ? {r_st.first_nibble, nib}
                   : (i_byte == htok_pkg::CH_PLUS) ? htok_pkg::CH_SP : i_byte;
    assign u_sep   = (r_st.phase == htok_pkg::PH_PATH)  ? htok_pkg::CH_QUES
                   : (r_st.phase == htok_pkg::PH_QNAME) ? htok_pkg::CH_EQ
                   : htok_pkg::CH_AMP;
    assign sep_hit = u_take && (u_dec == u_sep);
    assign kind    = htok_pkg::kind_of(r_st.phase);

    // Next state.
    always_comb begin
        n_step = r_st;
        unique case (r_st.phase)
            htok_pkg::PH_METHOD: begin
                if (i_byte == htok_pkg::CH_SP) n_step.phase = htok_pkg::PH_PATH;
            end
            htok_pkg::PH_PATH, htok_pkg::PH_QNAME, htok_pkg::PH_QVALUE: begin
                if (u_err) begin
                    n_step.phase = htok_pkg::PH_ERROR;
                end else if (r_st.escape_step == 2'd1) begin
                    n_step.first_nibble = nib;
                    n_step.escape_step  = 2'd2;
                end else if (r_st.escape_step == 2'd2) begin
                    n_step.escape_step  = 2'd0;
                    n_step.first_nibble = 4'd0;
                end else if (u_space) begin
                    n_step.name_open = 1'b0;
                    n_step.held_cr   = 1'b0;
                    n_step.phase     = htok_pkg::PH_VERSION;
                end else if (i_byte == htok_pkg::CH_PCT) begin
                    n_step.escape_step = 2'd1;
                end
                if (u_take) begin
                    if (sep_hit) begin
                        n_step.name_open = 1'b0;
                        n_step.phase = (r_st.phase == htok_pkg::PH_QNAME)
                                     ? htok_pkg::PH_QVALUE : htok_pkg::PH_QNAME;
                    end else if (r_st.phase == htok_pkg::PH_QNAME) begin
                        n_step.name_open = 1'b1;
                    end
                end
            end
            htok_pkg::PH_VERSION, htok_pkg::PH_HVALUE: begin
                if (!(r_st.phase == htok_pkg::PH_HVALUE && r_st.skipping_spaces
                      && i_byte == htok_pkg::CH_SP)) begin
                    n_step.skipping_spaces = 1'b0;
                    if (i_byte == htok_pkg::CH_LF) begin
                        n_step.held_cr    = 1'b0;
                        n_step.phase      = htok_pkg::PH_HNAME;
                        n_step.line_start = 1'b1;
                    end else begin
                        n_step.held_cr = (i_byte == htok_pkg::CH_CR);
                    end
                end
            end
            htok_pkg::PH_HNAME: begin
                priority if (r_st.line_start && i_byte == htok_pkg::CH_LF) begin
                    n_step.phase      = htok_pkg::PH_BODY;
                    n_step.line_start = 1'b0;
                end else if (r_st.line_start && i_byte == htok_pkg::CH_CR) begin
                    n_step.phase      = htok_pkg::PH_BLANK;
                    n_step.line_start = 1'b0;
                end else if (i_byte == htok_pkg::CH_LF) begin
                    n_step.phase = htok_pkg::PH_ERROR;
                end else if (i_byte == htok_pkg::CH_COLON) begin
                    n_step.phase           = htok_pkg::PH_HVALUE;
                    n_step.skipping_spaces = 1'b1;
                    n_step.held_cr         = 1'b0;
                    n_step.line_start      = 1'b0;
                end else begin
                    n_step.line_start = 1'b0;
                end
            end
            htok_pkg::PH_BLANK: begin
                if (i_byte == htok_pkg::CH_LF) n_step.phase = htok_pkg::PH_BODY;
            end
            default: begin
            end
        endcase
        // start over after the final word of a request
        n_st = i_eor ? htok_pkg::ST_RESET : n_step;
    end

    // Results.
    always_comb begin
        o_out.res = '0;
        o_out.cnt = 2'd0;
        unique case (r_st.phase)
            htok_pkg::PH_METHOD: begin
                o_out.res[0] = (i_byte == htok_pkg::CH_SP)
                    ? htok_pkg::mk_res(8'd0, htok_pkg::K_METHOD, 1'b1, 1'b0, htok_pkg::E_NONE)
                    : htok_pkg::mk_res(i_byte, htok_pkg::K_METHOD, 1'b0, 1'b0,
                                       htok_pkg::E_NONE);
                o_out.cnt = 2'd1;
            end
            htok_pkg::PH_PATH, htok_pkg::PH_QNAME, htok_pkg::PH_QVALUE: begin
                if (u_err) begin
                    o_out.res[0] = htok_pkg::mk_res(8'd0, kind, 1'b1, 1'b1, htok_pkg::E_ESCAPE);
                    o_out.cnt = 2'd1;
                end else if (u_space) begin
                    // an empty trailing name gives no marker
                    if (!(r_st.phase == htok_pkg::PH_QNAME && !r_st.name_open)) begin
                        o_out.res[0] = htok_pkg::mk_res(8'd0, kind, 1'b1,
                                                        r_st.phase == htok_pkg::PH_QNAME,
                                                        htok_pkg::E_NONE);
                        o_out.cnt = 2'd1;
                    end
                end else if (u_take) begin
                    o_out.res[0] = sep_hit
                        ? htok_pkg::mk_res(8'd0, kind, 1'b1, 1'b0, htok_pkg::E_NONE)
                        : htok_pkg::mk_res(u_dec, kind, 1'b0, 1'b0, htok_pkg::E_NONE);
                    o_out.cnt = 2'd1;
                end
            end
            htok_pkg::PH_VERSION, htok_pkg::PH_HVALUE: begin
                if (!(r_st.phase == htok_pkg::PH_HVALUE && r_st.skipping_spaces
                      && i_byte == htok_pkg::CH_SP)) begin
                    if (i_byte == htok_pkg::CH_LF) begin
                        o_out.res[0] = htok_pkg::mk_res(8'd0, kind, 1'b1, 1'b0,
                                                        htok_pkg::E_NONE);
                        o_out.cnt = 2'd1;
                    end else begin
                        // release a CR held back from the previous word
                        if (r_st.held_cr) begin
                            o_out.res[0] = htok_pkg::mk_res(htok_pkg::CH_CR, kind, 1'b0, 1'b0,
                                                            htok_pkg::E_NONE);
                            o_out.cnt = 2'd1;
                        end
                        if (i_byte != htok_pkg::CH_CR) begin
                            o_out.res[o_out.cnt] = htok_pkg::mk_res(i_byte, kind, 1'b0, 1'b0,
                                                                    htok_pkg::E_NONE);
                            o_out.cnt = o_out.cnt + 2'd1;
                        end
                    end
                end
            end
            htok_pkg::PH_HNAME: begin
                priority if (r_st.line_start && (i_byte == htok_pkg::CH_LF
                                                 || i_byte == htok_pkg::CH_CR)) begin
                    o_out.cnt = 2'd0;
                end else if (i_byte == htok_pkg::CH_LF) begin
                    o_out.res[0] = htok_pkg::mk_res(8'd0, htok_pkg::K_HNAME, 1'b1, 1'b1,
                                                    htok_pkg::E_NOCOLON);
                    o_out.cnt = 2'd1;
                end else if (i_byte == htok_pkg::CH_COLON) begin
                    o_out.res[0] = htok_pkg::mk_res(8'd0, htok_pkg::K_HNAME, 1'b1, 1'b0,
                                                    htok_pkg::E_NONE);
                    o_out.cnt = 2'd1;
                end else begin
                    o_out.res[0] = htok_pkg::mk_res(i_byte, htok_pkg::K_HNAME, 1'b0, 1'b0,
                                                    htok_pkg::E_NONE);
                    o_out.cnt = 2'd1;
                end
            end
            htok_pkg::PH_BODY: begin
                o_out.res[0] = htok_pkg::mk_res(i_byte, htok_pkg::K_BODY, 1'b0, 1'b0,
                                                htok_pkg::E_NONE);
                o_out.cnt = 2'd1;
            end
            default: begin
            end
        endcase
        if (i_eor) begin
            if (n_step.phase == htok_pkg::PH_BODY) begin
                o_out.res[o_out.cnt] = htok_pkg::mk_res(8'd0, htok_pkg::K_BODY, 1'b1, 1'b0,
                                                        htok_pkg::E_NONE);
                o_out.cnt = o_out.cnt + 2'd1;
            end else if (n_step.phase != htok_pkg::PH_ERROR) begin
                o_out.res[o_out.cnt] = htok_pkg::mk_res(8'd0, htok_pkg::kind_of(n_step.phase),
                                                        1'b1, 1'b1, htok_pkg::E_UNTERM);
                o_out.cnt = o_out.cnt + 2'd1;
            end
        end
        if (o_out.cnt != 2'd0) o_out.res[o_out.cnt - 2'd1].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= htok_pkg::ST_RESET;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    `CHK_NEXT(a_eor_clears, i_fire && i_eor,
        r_st.phase == htok_pkg::PH_METHOD && r_st.escape_step == 2'd0,
        "state not cleared after end of request")
    `CHK_SAME(a_error_silent, i_fire && !i_eor && r_st.phase == htok_pkg::PH_ERROR,
        o_out.cnt == 2'd0, "output produced while in error phase")

endmodule

// ===== hw/rtl/htok_resq.sv =====
// Result queue: takes up to three results a cycle, delivers one a cycle while the output is not stalled.
`include "assert_macros.svh"

module htok_resq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  htok_pkg::t_res_set   i_push,
    input  logic [1:0]           i_push_cnt,
    input  logic                 i_stall,
    output logic                 o_room,
    output logic                 o_valid,
    output htok_pkg::t_result    o_head
);

    htok_pkg::t_result           r_mem [htok_pkg::RQ_DEPTH];
    logic [htok_pkg::RQ_AW-1:0]  r_wr;
    logic [htok_pkg::RQ_AW-1:0]  r_rd;
    logic [htok_pkg::RQ_CW-1:0]  r_count;
    logic                        pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    // room for a full set of results without looking at this cycle's pop
    assign o_room  = (r_count <= htok_pkg::RQ_CW'(htok_pkg::RQ_ROOM));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < htok_pkg::MAX_RES; k++) begin
            if (2'(k) < i_push_cnt) r_mem[r_wr + htok_pkg::RQ_AW'(k)] <= i_push[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + htok_pkg::RQ_AW'(i_push_cnt);
            r_rd    <= r_rd + htok_pkg::RQ_AW'(pop);
            r_count <= r_count + htok_pkg::RQ_CW'(i_push_cnt) - htok_pkg::RQ_CW'(pop);
        end
    end

    `CHK_SAME(a_push_room, i_push_cnt != 2'd0,
        r_count <= htok_pkg::RQ_CW'(htok_pkg::RQ_ROOM), "push without room")
    `CHK_SAME(a_count_max, 1'b1,
        r_count <= htok_pkg::RQ_CW'(htok_pkg::RQ_DEPTH), "queue overfilled")

endmodule

// ===== hw/rtl/http_request_tokenizer.sv =====
// Top level of the HTTP request tokenizer: input register, parser, result queue.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------------
//  in      | i_valid | o_stall | i_data_byte, i_end_of_request
//  out     | o_valid | i_stall | o_out_byte, o_field_kind, o_field_end,
//          |         |         | o_discard_field, o_error_code, o_last_of_run
//
// A word waits in the input register until the queue has room; it is then parsed and its
// results are written to the queue, whose head is the output. Each word makes zero to three
// results. Input runs at one word a cycle while each word makes at most one result and the
// output is not stalled; otherwise it holds until the four-entry queue is down to one entry.
// Reset (synchronous, active low) returns the parser to the method phase and empties
// the queue. A stall on the output fills the queue and then holds input.

module http_request_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_request,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_field_kind,
    output logic       o_field_end,
    output logic       o_discard_field,
    output logic [1:0] o_error_code,
    output logic       o_last_of_run
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_eor;
    logic                room;
    logic                consume;
    logic                accept;
    logic [1:0]          push_cnt;
    htok_pkg::t_step_out step_out;
    htok_pkg::t_result   head;

    assign consume  = r_in_valid && room;
    assign o_stall  = r_in_valid && !room;
    assign accept   = i_valid && !o_stall;
    assign push_cnt = consume ? step_out.cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !consume);
        end
    end

    // hold the word until the parser takes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eor  <= i_end_of_request;
        end
    end

    htok_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (consume),
        .i_byte  (r_in_byte),
        .i_eor   (r_in_eor),
        .o_out   (step_out)
    );

    htok_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step_out.res),
        .i_push_cnt (push_cnt),
        .i_stall    (i_stall),
        .o_room     (room),
        .o_valid    (o_valid),
        .o_head     (head)
    );

    assign o_out_byte      = head.out_byte;
    assign o_field_kind    = head.field_kind;
    assign o_field_end     = head.field_end;
    assign o_discard_field = head.discard_field;
    assign o_error_code    = head.error_code;
    assign o_last_of_run   = head.last_of_run;

endmodule

// ===== bench/tb_http_request_tokenizer.sv =====
// Self-checking testbench for the HTTP request tokenizer: random and directed requests.
`timescale 1ns / 100ps

module tb_http_request_tokenizer;

    localparam int CLK_HALF      = 5;
    localparam int RANDOM_WORDS  = 350;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       eor;
    } t_req_word;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_BURSTY
    } t_sink_mode;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic [7:0] i_data_byte      = 8'd0;
    logic       i_end_of_request = 1'b0;
    logic       i_stall          = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_field_kind;
    logic       o_field_end;
    logic       o_discard_field;
    logic [1:0] o_error_code;
    logic       o_last_of_run;

    http_request_tokenizer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_request (i_end_of_request),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_field_kind     (o_field_kind),
        .o_field_end      (o_field_end),
        .o_discard_field  (o_discard_field),
        .o_error_code     (o_error_code),
        .o_last_of_run    (o_last_of_run)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tokenizer predictor
    // ------------------------------------------------------------------
    htok_pkg::t_phase tk_phase;
    logic [1:0]       tk_esc;
    logic [3:0]       tk_nib;
    bit               tk_held_cr;
    bit               tk_line_start;
    bit               tk_skip_sp;
    bit               tk_name_open;

    htok_pkg::t_result step_tokens[$];
    htok_pkg::t_result want_tokens[$];

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic logic [2:0] field_of(htok_pkg::t_phase p);
        case (p)
            htok_pkg::PH_METHOD:  return htok_pkg::K_METHOD;
            htok_pkg::PH_PATH:    return htok_pkg::K_PATH;
            htok_pkg::PH_QNAME:   return htok_pkg::K_QNAME;
            htok_pkg::PH_QVALUE:  return htok_pkg::K_QVALUE;
            htok_pkg::PH_VERSION: return htok_pkg::K_VERSION;
            htok_pkg::PH_HNAME:   return htok_pkg::K_HNAME;
            htok_pkg::PH_HVALUE:  return htok_pkg::K_HVALUE;
            htok_pkg::PH_BLANK, htok_pkg::PH_BODY: return htok_pkg::K_BODY;
            default:              return htok_pkg::K_METHOD;
        endcase
    endfunction

    task automatic clear_tok_state();
        tk_phase      = htok_pkg::PH_METHOD;
        tk_esc        = 2'd0;
        tk_nib        = 4'd0;
        tk_held_cr    = 1'b0;
        tk_line_start = 1'b0;
        tk_skip_sp    = 1'b0;
        tk_name_open  = 1'b0;
    endtask

    task automatic put_token(logic [7:0] b, logic [2:0] k, logic fe, logic dc, logic [1:0] ec);
        htok_pkg::t_result r;
        r.out_byte      = b;
        r.field_kind    = k;
        r.field_end     = fe;
        r.discard_field = dc;
        r.error_code    = ec;
        r.last_of_run   = 1'b0;
        if (step_tokens.size() < htok_pkg::MAX_RES) step_tokens.push_back(r);
    endtask

    task automatic flag_error(logic [1:0] ec);
        put_token(8'd0, field_of(tk_phase), 1'b1, 1'b1, ec);
        tk_phase = htok_pkg::PH_ERROR;
    endtask

    task automatic take_decoded(logic [7:0] d);
        case (tk_phase)
            htok_pkg::PH_PATH: begin
                if (d == htok_pkg::CH_QUES) begin
                    put_token(8'd0, htok_pkg::K_PATH, 1'b1, 1'b0, htok_pkg::E_NONE);
                    tk_phase     = htok_pkg::PH_QNAME;
                    tk_name_open = 1'b0;
                end else begin
                    put_token(d, htok_pkg::K_PATH, 1'b0, 1'b0, htok_pkg::E_NONE);
                end
            end
            htok_pkg::PH_QNAME: begin
                if (d == htok_pkg::CH_EQ) begin
                    put_token(8'd0, htok_pkg::K_QNAME, 1'b1, 1'b0, htok_pkg::E_NONE);
                    tk_phase     = htok_pkg::PH_QVALUE;
                    tk_name_open = 1'b0;
                end else begin
                    put_token(d, htok_pkg::K_QNAME, 1'b0, 1'b0, htok_pkg::E_NONE);
                    tk_name_open = 1'b1;
                end
            end
            default: begin
                if (d == htok_pkg::CH_AMP) begin
                    put_token(8'd0, htok_pkg::K_QVALUE, 1'b1, 1'b0, htok_pkg::E_NONE);
                    tk_phase     = htok_pkg::PH_QNAME;
                    tk_name_open = 1'b0;
                end else begin
                    put_token(d, htok_pkg::K_QVALUE, 1'b0, 1'b0, htok_pkg::E_NONE);
                end
            end
        endcase
    endtask

    task automatic uri_char(logic [7:0] c);
        int h;
        h = nibble_of(c);
        if (tk_esc == 2'd1) begin
            if (h < 0) begin
                flag_error(htok_pkg::E_ESCAPE);
            end else begin
                tk_nib = h[3:0];
                tk_esc = 2'd2;
            end
        end else if (tk_esc == 2'd2) begin
            if (h < 0) begin
                flag_error(htok_pkg::E_ESCAPE);
            end else begin
                tk_esc = 2'd0;
                take_decoded({tk_nib, h[3:0]});
                tk_nib = 4'd0;
            end
        end else if (c == htok_pkg::CH_SP) begin
            // raw space closes the URI; an open query name is dropped
            if (tk_phase == htok_pkg::PH_PATH) begin
                put_token(8'd0, htok_pkg::K_PATH, 1'b1, 1'b0, htok_pkg::E_NONE);
            end else if (tk_phase == htok_pkg::PH_QNAME) begin
                if (tk_name_open)
                    put_token(8'd0, htok_pkg::K_QNAME, 1'b1, 1'b1, htok_pkg::E_NONE);
            end else begin
                put_token(8'd0, htok_pkg::K_QVALUE, 1'b1, 1'b0, htok_pkg::E_NONE);
            end
            tk_name_open = 1'b0;
            tk_held_cr   = 1'b0;
            tk_phase     = htok_pkg::PH_VERSION;
        end else if (c == htok_pkg::CH_PCT) begin
            tk_esc = 2'd1;
        end else if (c == htok_pkg::CH_PLUS) begin
            take_decoded(htok_pkg::CH_SP);
        end else begin
            take_decoded(c);
        end
    endtask

    // Hold a CR until the next byte shows whether it precedes LF.
    task automatic line_char(logic [7:0] c, logic [2:0] k);
        if (c == htok_pkg::CH_LF) begin
            tk_held_cr = 1'b0;
            put_token(8'd0, k, 1'b1, 1'b0, htok_pkg::E_NONE);
            tk_phase      = htok_pkg::PH_HNAME;
            tk_line_start = 1'b1;
            tk_skip_sp    = 1'b0;
        end else begin
            if (tk_held_cr) put_token(htok_pkg::CH_CR, k, 1'b0, 1'b0, htok_pkg::E_NONE);
            if (c == htok_pkg::CH_CR) begin
                tk_held_cr = 1'b1;
            end else begin
                tk_held_cr = 1'b0;
                put_token(c, k, 1'b0, 1'b0, htok_pkg::E_NONE);
            end
        end
    endtask

    task automatic tokenize_byte(logic [7:0] c, logic eor);
        htok_pkg::t_result r;
        step_tokens.delete();
        case (tk_phase)
            htok_pkg::PH_METHOD: begin
                if (c == htok_pkg::CH_SP) begin
                    put_token(8'd0, htok_pkg::K_METHOD, 1'b1, 1'b0, htok_pkg::E_NONE);
                    tk_phase = htok_pkg::PH_PATH;
                end else begin
                    put_token(c, htok_pkg::K_METHOD, 1'b0, 1'b0, htok_pkg::E_NONE);
                end
            end
            htok_pkg::PH_PATH, htok_pkg::PH_QNAME, htok_pkg::PH_QVALUE: uri_char(c);
            htok_pkg::PH_VERSION: line_char(c, htok_pkg::K_VERSION);
            htok_pkg::PH_HNAME: begin
                if (tk_line_start && c == htok_pkg::CH_LF) begin
                    tk_phase      = htok_pkg::PH_BODY;
                    tk_line_start = 1'b0;
                end else if (tk_line_start && c == htok_pkg::CH_CR) begin
                    tk_phase      = htok_pkg::PH_BLANK;
                    tk_line_start = 1'b0;
                end else if (c == htok_pkg::CH_LF) begin
                    flag_error(htok_pkg::E_NOCOLON);
                end else if (c == htok_pkg::CH_COLON) begin
                    put_token(8'd0, htok_pkg::K_HNAME, 1'b1, 1'b0, htok_pkg::E_NONE);
                    tk_phase      = htok_pkg::PH_HVALUE;
                    tk_skip_sp    = 1'b1;
                    tk_held_cr    = 1'b0;
                    tk_line_start = 1'b0;
                end else begin
                    put_token(c, htok_pkg::K_HNAME, 1'b0, 1'b0, htok_pkg::E_NONE);
                    tk_line_start = 1'b0;
                end
            end
            htok_pkg::PH_HVALUE: begin
                if (!(tk_skip_sp && c == htok_pkg::CH_SP)) begin
                    tk_skip_sp = 1'b0;
                    line_char(c, htok_pkg::K_HVALUE);
                end
            end
            htok_pkg::PH_BLANK: if (c == htok_pkg::CH_LF) tk_phase = htok_pkg::PH_BODY;
            htok_pkg::PH_BODY: put_token(c, htok_pkg::K_BODY, 1'b0, 1'b0, htok_pkg::E_NONE);
            default: ;
        endcase

        if (eor) begin
            if (tk_phase == htok_pkg::PH_BODY)
                put_token(8'd0, htok_pkg::K_BODY, 1'b1, 1'b0, htok_pkg::E_NONE);
            else if (tk_phase != htok_pkg::PH_ERROR)
                flag_error(htok_pkg::E_UNTERM);
            clear_tok_state();
        end

        if (step_tokens.size() > 0) begin
            r = step_tokens.pop_back();
            r.last_of_run = 1'b1;
            step_tokens.push_back(r);
        end
        while (step_tokens.size() > 0) want_tokens.push_back(step_tokens.pop_front());
    endtask

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    t_req_word  pending_words[$];
    logic [7:0] req_buf[$];
    int         words_total;
    int         words_accepted;
    int         random_words;
    int         requests_built;

    task automatic add_char(logic [7:0] c);
        req_buf.push_back(c);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) req_buf.push_back(s[i]);
    endtask

    task automatic add_eol(bit crlf);
        if (crlf) add_char(htok_pkg::CH_CR);
        add_char(htok_pkg::CH_LF);
    endtask

    // Queue the first cut bytes as one request, end flag on the final one.
    task automatic flush_request(int cut);
        t_req_word w;
        for (int i = 0; i < cut; i++) begin
            w.data = req_buf[i];
            w.eor  = (i == cut - 1);
            pending_words.push_back(w);
        end
        requests_built++;
        req_buf.delete();
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 10) return 8'("0") + 8'(v);
        return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1)) return 8'("a") + 8'($urandom_range(0, 25));
        return 8'("A") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (nibble_of(c) >= 0) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_value_char();
        case ($urandom_range(0, 5))
            0:       return htok_pkg::CH_SP;
            1:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic add_uri_piece();
        int         sel;
        logic [7:0] v;
        logic [7:0] c;
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
            add_char(($urandom_range(0, 2) == 0) ? 8'("/") : pick_letter());
        end else if (sel < 14) begin
            case ($urandom_range(0, 7))
                0: v = htok_pkg::CH_QUES;
                1: v = htok_pkg::CH_EQ;
                2: v = htok_pkg::CH_AMP;
                3: v = htok_pkg::CH_SP;
                4: v = htok_pkg::CH_PCT;
                5: v = htok_pkg::CH_PLUS;
                default: v = 8'($urandom_range(0, 255));
            endcase
            add_char(htok_pkg::CH_PCT);
            add_char(hex_char(v[7:4], $urandom_range(0, 1)));
            add_char(hex_char(v[3:0], $urandom_range(0, 1)));
        end else if (sel < 16) begin
            add_char(htok_pkg::CH_PLUS);
        end else if (sel == 16) begin
            add_char(htok_pkg::CH_QUES);
        end else if (sel == 17) begin
            add_char(htok_pkg::CH_EQ);
        end else if (sel == 18) begin
            add_char(htok_pkg::CH_AMP);
        end else begin
            c = 8'($urandom_range(0, 255));
            while (c == htok_pkg::CH_SP || c == htok_pkg::CH_PCT)
                c = 8'($urandom_range(0, 255));
            add_char(c);
        end
    endtask

    // Mostly well-formed requests; some truncated, badly escaped, colonless or noise.
    task automatic gen_request();
        int shape;
        int n;
        int cut;
        shape = $urandom_range(0, 9);
        n = $urandom_range(1, 4);
        repeat (n) add_char(pick_letter());
        add_char(htok_pkg::CH_SP);
        add_char("/");
        n = $urandom_range(0, 6);
        repeat (n) add_uri_piece();
        if (shape == 7) begin
            add_char(htok_pkg::CH_PCT);
            if ($urandom_range(0, 1)) add_char(hex_char(4'($urandom_range(0, 15)), 1'b1));
            add_char(pick_nonhex());
        end
        add_char(htok_pkg::CH_SP);
        add_text("H/");
        n = $urandom_range(0, 3);
        repeat (n) add_char(8'("0") + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0) begin
            add_char(htok_pkg::CH_CR);
            add_char(pick_letter());
        end
        add_eol($urandom_range(0, 3) != 0);
        n = $urandom_range(0, 2);
        for (int h = 0; h < n; h++) begin
            repeat ($urandom_range(1, 3)) add_char(pick_letter());
            if (shape == 8 && h == 0) begin
                add_eol($urandom_range(0, 1));
            end else begin
                add_char(htok_pkg::CH_COLON);
                repeat ($urandom_range(0, 2)) add_char(htok_pkg::CH_SP);
                repeat ($urandom_range(0, 4)) add_char(pick_value_char());
                if ($urandom_range(0, 5) == 0) begin
                    add_char(htok_pkg::CH_CR);
                    add_char(pick_letter());
                end
                add_eol($urandom_range(0, 3) != 0);
            end
        end
        if (shape == 8 && n == 0) begin
            add_char(pick_letter());
            add_eol(1'b1);
        end
        case ($urandom_range(0, 5))
            0, 1, 2: add_eol(1'b1);
            3, 4:    add_eol(1'b0);
            default: begin
                // blank line with junk between its CR and LF
                add_char(htok_pkg::CH_CR);
                repeat ($urandom_range(1, 2)) add_char(8'($urandom_range(0, 255)) | 8'h01);
                add_char(htok_pkg::CH_LF);
            end
        endcase
        repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(0, 255)));
        if (shape == 9) begin
            req_buf.delete();
            repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
        end
        cut = (shape == 6) ? $urandom_range(1, req_buf.size()) : req_buf.size();
        random_words += cut;
        flush_request(cut);
    endtask

    task automatic build_directed();
        // extreme bytes in the method, escapes, plus, query split, dropped name,
        // stray CR in version, leading spaces, blank line with CR and junk, body
        add_char(8'h00);
        add_char(8'hFF);
        add_text(" /%4A+?n=%3d&b V");
        add_char(htok_pkg::CH_CR);
        add_char("x");
        add_eol(1'b1);
        add_text("k:  v");
        add_eol(1'b1);
        add_char(htok_pkg::CH_CR);
        add_char("q");
        add_char(htok_pkg::CH_LF);
        add_char("Z");
        flush_request(req_buf.size());
        // bad escape, then ignored bytes
        add_text("G /%fgab");
        flush_request(req_buf.size());
        // header line without a colon
        add_text("G / V");
        add_eol(1'b0);
        add_text("bad");
        add_eol(1'b0);
        flush_request(req_buf.size());
        // request ending on the LF that opens the body
        add_text("G / V");
        add_eol(1'b0);
        add_eol(1'b0);
        flush_request(req_buf.size());
        // ends inside the method
        add_char("G");
        flush_request(req_buf.size());
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_proc
        logic      nv;
        t_req_word nw;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_tok_state();
        end else begin
            nv = i_valid;
            if (i_valid && !o_stall) begin
                tokenize_byte(i_data_byte, i_end_of_request);
                words_accepted++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    nw = pending_words.pop_front();
                    nv = 1'b1;
                    i_data_byte      <= nw.data;
                    i_end_of_request <= nw.eor;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: rotates through open, random, periodic, bursty
    // ------------------------------------------------------------------
    int sink_cycle = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin : sink_proc
        logic       ns;
        t_sink_mode mode;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            sink_cycle++;
            mode = t_sink_mode'((sink_cycle / 97) % 4);
            case (mode)
                SINK_OPEN:     ns = 1'b0;
                SINK_RANDOM:   ns = ($urandom_range(0, 3) == 0);
                SINK_PERIODIC: ns = ((sink_cycle % 8) < 3);
                default: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        ns = 1'b1;
                    end else if ($urandom_range(0, 19) == 0) begin
                        hold_left = $urandom_range(4, 11);
                        ns = 1'b1;
                    end else begin
                        ns = 1'b0;
                    end
                end
            endcase
            i_stall <= ns;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each delivered token with the oldest prediction
    // ------------------------------------------------------------------
    int mismatches    = 0;
    int tokens_seen   = 0;
    int error_markers = 0;
    int dropped_names = 0;

    always @(posedge i_clk) begin : check_proc
        htok_pkg::t_result w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (want_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"unexpected token, expected none: ",
                              "byte=%h kind=%0d end=%b discard=%b err=%0d last=%b"},
                             o_out_byte, o_field_kind, o_field_end, o_discard_field,
                             o_error_code, o_last_of_run);
            end else begin
                w = want_tokens.pop_front();
                if (o_out_byte !== w.out_byte || o_field_kind !== w.field_kind ||
                    o_field_end !== w.field_end || o_discard_field !== w.discard_field ||
                    o_error_code !== w.error_code || o_last_of_run !== w.last_of_run) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display({"token %0d expected: ",
                                  "byte=%h kind=%0d end=%b discard=%b err=%0d last=%b"},
                                 tokens_seen, w.out_byte, w.field_kind, w.field_end,
                                 w.discard_field, w.error_code, w.last_of_run);
                        $display({"token %0d actual:   ",
                                  "byte=%h kind=%0d end=%b discard=%b err=%0d last=%b"},
                                 tokens_seen, o_out_byte, o_field_kind, o_field_end,
                                 o_discard_field, o_error_code, o_last_of_run);
                    end
                end
                if (w.error_code != htok_pkg::E_NONE) error_markers++;
                else if (w.discard_field) dropped_names++;
                tokens_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no word moving on either channel for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles, %0d of %0d words accepted",
                         idle_cycles, words_accepted, words_total);
                $display("http_request_tokenizer test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_proc
        words_accepted = 0;
        random_words   = 0;
        requests_built = 0;
        build_directed();
        while (random_words < RANDOM_WORDS) gen_request();
        words_total = pending_words.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (words_accepted < words_total || want_tokens.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (want_tokens.size() > 0)
            $display("%0d predicted tokens never delivered", want_tokens.size());
        $display("covered %0d requests, %0d words, %0d tokens checked",
                 requests_built, words_accepted, tokens_seen);
        $display("%0d error markers, %0d dropped query names, %0d mismatches",
                 error_markers, dropped_names, mismatches);
        if (mismatches == 0 && want_tokens.size() == 0) begin
            $display("http_request_tokenizer test passed");
        end else begin
            $display("http_request_tokenizer test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/htok_pkg.sv
hw/rtl/htok_step.sv
hw/rtl/htok_resq.sv
hw/rtl/http_request_tokenizer.sv
bench/tb_http_request_tokenizer.sv
